>>> sv/assert_macros.svh
// Assertion macros for the checker file of the spin yaw braking block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define SYB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define SYB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/syb_pkg.sv
// Shared types and constants of the spin yaw braking profile block
package syb_pkg;

    // pi scaled by 2^32, rounded; scaled down to the angle format at elaboration
    localparam longint PI_Q32 = 64'd13493037705;

    // Input word kinds
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_RUN  = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_FAIL = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_RATE = 2'd0;
    localparam logic [1:0] CFG_MIN_RATE = 2'd1;
    localparam logic [1:0] CFG_ACCEL    = 2'd2;

    // Configuration reset values
    localparam logic [14:0] MAX_RATE_RST = 15'd4096;
    localparam logic [14:0] MIN_RATE_RST = 15'd1638;
    localparam logic [15:0] ACCEL_RST    = 16'd13107;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_REM,
        S_MUL,
        S_SQRT,
        S_CLAMP,
        S_EMIT
    } t_state;

endpackage

>>> sv/syb_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle
module syb_mul #(
    parameter int AW = 24,
    parameter int BW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [AW-1:0]        i_a,
    input  logic [BW-1:0]        i_b,
    output logic                 o_done,
    output logic [AW+BW-1:0]     o_product
);

    localparam int CW = $clog2(BW + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [AW-1:0]     r_a;
    logic [AW+BW-1:0]  r_p, n_p;
    logic [AW:0]       w_sum;

    // Add the multiplicand into the upper half when the low bit is set, then shift right
    always_comb begin
        w_sum  = {1'b0, r_p[AW+BW-1:BW]} + (r_p[0] ? {1'b0, r_a} : '0);
        n_p    = r_p;
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_p    = {{AW{1'b0}}, i_b};
            n_busy = 1'b1;
            n_cnt  = CW'(BW);
        end else if (r_busy) begin
            n_p   = {w_sum, r_p[BW-1:1]};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Hold operands and partial product
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
        end
        r_p <= n_p;
    end

    assign o_done    = r_done;
    assign o_product = r_p;

endmodule

>>> sv/syb_sqrt.sv
// Digit-serial restoring integer square root, two radicand bits per cycle
module syb_sqrt #(
    parameter int XW = 41
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [XW-1:0]               i_x,
    output logic                        o_done,
    output logic [(XW+(XW%2))/2-1:0]    o_root
);

    localparam int XE = XW + (XW % 2);
    localparam int RW = XE / 2;
    localparam int CW = $clog2(RW + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [XE-1:0]     r_x, n_x;
    logic [RW-1:0]     r_rem, n_rem;
    logic [RW-1:0]     r_root, n_root;
    logic [RW+1:0]     w_rem_sh;
    logic [RW+1:0]     w_trial;
    logic [RW+1:0]     w_diff;
    logic              w_ge;

    // Bring down two radicand bits and try the next root digit
    always_comb begin
        w_rem_sh = {r_rem, r_x[XE-1 -: 2]};
        w_trial  = {r_root, 2'b01};
        w_ge     = (w_rem_sh >= w_trial);
        w_diff   = w_rem_sh - w_trial;
        n_x      = r_x;
        n_rem    = r_rem;
        n_root   = r_root;
        n_busy   = r_busy;
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        if (i_start) begin
            n_x    = XE'(i_x);
            n_rem  = '0;
            n_root = '0;
            n_busy = 1'b1;
            n_cnt  = CW'(RW);
        end else if (r_busy) begin
            n_x    = {r_x[XE-3:0], 2'b00};
            n_rem  = w_ge ? w_diff[RW-1:0] : w_rem_sh[RW-1:0];
            n_root = {r_root[RW-2:0], w_ge};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Hold radicand, partial remainder and root
    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> sv/spin_yaw_braking_profile_core.sv
// Top level of the spin yaw braking profile: unwrap, accumulate, sqrt braking rate
//
//  channel   | dir | handshake                        | payload
//  ----------+-----+----------------------------------+------------------------------------
//  s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready| tdata heading, target_turn; tuser op, pose_valid
//  m_axis    | out | o_m_axis_tvalid / i_m_axis_tready| tdata rate_command, turned_angle; tuser status
//  cfg       | in  | i_cfg_valid / o_cfg_ready        | i_cfg_index, i_cfg_data
//
// One word at a time. A start word or a word without pose goes through S_UPDATE and S_EMIT,
// a sample that has reached its goal also through S_REM; a running sample also waits in
// S_MUL and S_SQRT on the bit-serial multiplier (one accel_limit bit a cycle) and the square
// root (two radicand bits a cycle), then passes S_CLAMP. The input reopens as the result
// enters the output register. Synchronous active-low reset clears the sequencer, configuration,
// spin state and output valid; no clearing pass. A result stalled at the output holds the block
// in its last step only once the output register is full; the next word is taken while it waits.
module spin_yaw_braking_profile_core import syb_pkg::*; #(
    parameter int FRAC_BITS       = 12,
    parameter int ANGLE_ACC_WIDTH = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [14:0] heading, [38:15] target_turn, [39] zero
    input  logic [1:0]  i_s_axis_tuser,   // [0] op, [1] pose_valid
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [15:0] rate_command, [39:16] turned_angle
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int W  = ANGLE_ACC_WIDTH;
    localparam int DW = (FRAC_BITS + 4 > 17) ? FRAC_BITS + 4 : 17;
    localparam int SW = ((W > DW) ? W : DW) + 1;
    localparam int TW = (W > 24) ? W : 24;
    localparam int PW = W + 16;
    localparam int XW = PW + 1;
    localparam int RW = (XW + (XW % 2)) / 2;

    localparam longint PI_Q     = (PI_Q32 + (longint'(1) << (31 - FRAC_BITS)))
                                  >>> (32 - FRAC_BITS);
    localparam longint TWO_PI_Q = (2 * PI_Q32 + (longint'(1) << (31 - FRAC_BITS)))
                                  >>> (32 - FRAC_BITS);
    localparam longint ACC_HI_L = (longint'(1) << (W - 1)) - 1;
    localparam longint ACC_LO_L = -ACC_HI_L - 1;

    localparam logic signed [DW-1:0] PI_D     = DW'(PI_Q);
    localparam logic signed [DW-1:0] NPI_D    = DW'(-PI_Q);
    localparam logic signed [DW-1:0] TWO_PI_D = DW'(TWO_PI_Q);
    localparam logic signed [SW-1:0] ACC_HI_S = SW'(ACC_HI_L);
    localparam logic signed [SW-1:0] ACC_LO_S = SW'(ACC_LO_L);
    localparam logic signed [TW-1:0] ACC_HI_T = TW'(ACC_HI_L);
    localparam logic signed [TW-1:0] ACC_LO_T = TW'(ACC_LO_L);

    t_state r_state, n_state;

    // configuration registers
    logic [14:0]           r_max_rate;
    logic [14:0]           r_min_rate;
    logic [15:0]           r_accel;

    // captured input word
    logic                  r_in_op;
    logic                  r_in_valid;
    logic signed [14:0]    r_in_heading;
    logic signed [23:0]    r_in_target;

    // spin state
    logic signed [14:0]    r_last;
    logic signed [W-1:0]   r_turned;
    logic signed [W-1:0]   r_goal;

    // result under construction and output register
    logic [1:0]            r_res_status;
    logic signed [15:0]    r_res_rate;
    logic                  r_m_valid;
    logic [1:0]            r_m_status;
    logic [15:0]           r_m_rate;
    logic [23:0]           r_m_turned;

    logic                  w_in_acc;
    logic                  w_cfg_acc;
    logic                  w_out_free;
    logic signed [DW-1:0]  w_d_raw;
    logic signed [DW-1:0]  w_d_unw;
    logic signed [SW-1:0]  w_sum;
    logic signed [W-1:0]   w_sum_sat;
    logic signed [TW-1:0]  w_tgt;
    logic signed [W-1:0]   w_tgt_sat;
    logic signed [W:0]     w_abs_goal;
    logic signed [W:0]     w_abs_turned;
    logic signed [W+1:0]   w_rem;
    logic                  w_rem_pos;
    logic [RW-1:0]         w_low;
    logic [14:0]           w_vel;
    logic signed [63:0]    w_turned_ext;

    logic                  w_mul_start;
    logic                  w_mul_done;
    logic [PW-1:0]         w_product;
    logic                  w_sqrt_done;
    logic [RW-1:0]         w_root;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign w_out_free = !r_m_valid || i_m_axis_tready;

    // Unwrap the heading change and saturate the accumulated turn
    always_comb begin
        w_d_raw = DW'(r_in_heading) - DW'(r_last);
        priority if (w_d_raw > PI_D) begin
            w_d_unw = w_d_raw - TWO_PI_D;
        end else if (w_d_raw < NPI_D) begin
            w_d_unw = w_d_raw + TWO_PI_D;
        end else begin
            w_d_unw = w_d_raw;
        end
        w_sum = SW'(r_turned) + SW'(w_d_unw);
        priority if (w_sum > ACC_HI_S) begin
            w_sum_sat = W'(ACC_HI_S);
        end else if (w_sum < ACC_LO_S) begin
            w_sum_sat = W'(ACC_LO_S);
        end else begin
            w_sum_sat = W'(w_sum);
        end
    end

    // Saturate the commanded turn into the accumulator width
    always_comb begin
        w_tgt = TW'(r_in_target);
        priority if (w_tgt > ACC_HI_T) begin
            w_tgt_sat = W'(ACC_HI_T);
        end else if (w_tgt < ACC_LO_T) begin
            w_tgt_sat = W'(ACC_LO_T);
        end else begin
            w_tgt_sat = W'(w_tgt);
        end
    end

    // Remaining angle from the magnitudes of goal and turned total
    always_comb begin
        w_abs_goal   = r_goal[W-1] ? -((W+1)'(r_goal)) : (W+1)'(r_goal);
        w_abs_turned = r_turned[W-1] ? -((W+1)'(r_turned)) : (W+1)'(r_turned);
        w_rem        = (W+2)'(w_abs_goal) - (W+2)'(w_abs_turned);
        w_rem_pos    = !w_rem[W+1] && (w_rem != '0);
    end

    // Clamp the root up to min_rate, then down to max_rate
    always_comb begin
        w_low = (w_root < RW'(r_min_rate)) ? RW'(r_min_rate) : w_root;
        w_vel = (w_low > RW'(r_max_rate)) ? r_max_rate : w_low[14:0];
    end

    assign w_turned_ext = 64'(r_turned);

    // accel_limit * remaining, one accel bit a cycle; doubled at the square root input
    syb_mul #(
        .AW (W),
        .BW (16)
    ) u_syb_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_a       (w_rem[W-1:0]),
        .i_b       (r_accel),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    // floor(sqrt(.)), two radicand bits a cycle
    syb_sqrt #(
        .XW (XW)
    ) u_syb_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_done),
        .i_x     ({w_product, 1'b0}),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (!r_in_valid || (r_in_op == OP_START)) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_REM;
                end
            end
            S_REM: begin
                n_state = w_rem_pos ? S_MUL : S_EMIT;
            end
            S_MUL: begin
                if (w_mul_done) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (w_sqrt_done) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        w_mul_start     = (r_state == S_REM) && w_rem_pos;
    end

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rate <= MAX_RATE_RST;
            r_min_rate <= MIN_RATE_RST;
            r_accel    <= ACCEL_RST;
        end else if (w_cfg_acc) begin
            unique case (i_cfg_index)
                CFG_MAX_RATE: r_max_rate <= i_cfg_data[14:0];
                CFG_MIN_RATE: r_min_rate <= i_cfg_data[14:0];
                CFG_ACCEL:    r_accel    <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_op      <= i_s_axis_tuser[0];
            r_in_valid   <= i_s_axis_tuser[1];
            r_in_heading <= i_s_axis_tdata[14:0];
            r_in_target  <= i_s_axis_tdata[38:15];
        end
    end

    // Update spin state; a word without pose leaves it untouched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= '0;
            r_turned <= '0;
            r_goal   <= '0;
        end else if ((r_state == S_UPDATE) && r_in_valid) begin
            r_last <= r_in_heading;
            if (r_in_op == OP_START) begin
                r_turned <= '0;
                r_goal   <= w_tgt_sat;
            end else begin
                r_turned <= w_sum_sat;
            end
        end
    end

    // Build status and rate of the current word
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_UPDATE: begin
                r_res_status <= r_in_valid ? ST_RUN : ST_FAIL;
                r_res_rate   <= '0;
            end
            S_REM: begin
                r_res_status <= w_rem_pos ? ST_RUN : ST_DONE;
                r_res_rate   <= '0;
            end
            S_CLAMP: begin
                r_res_rate <= r_goal[W-1] ? -$signed({1'b0, w_vel}) : $signed({1'b0, w_vel});
            end
            default: ;
        endcase
    end

    // Output register: load on emit when free, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && w_out_free) begin
            r_m_status <= r_res_status;
            r_m_rate   <= r_res_rate;
            r_m_turned <= w_turned_ext[23:0];
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {r_m_turned, r_m_rate};
    assign o_m_axis_tuser  = r_m_status;

endmodule

>>> sv/syb_checker.sv
// Port-level checks of the spin yaw braking profile block, bound to the top level
`include "assert_macros.svh"

module syb_checker import syb_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] i_m_tdata,
    input logic [1:0]  i_m_tuser
);

    logic w_in_acc;
    logic w_out_stall;

    assign w_in_acc    = i_s_tvalid && i_s_tready;
    assign w_out_stall = i_m_tvalid && !i_m_tready;

    // A stalled result word holds its contents
    `SYB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall,
        i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser), "result word changed under stall")

    // Only one word is in work: the input closes right after an accept
    `SYB_ASSERT_NEXT(a_one_in_work, i_clk, i_rst_n, w_in_acc,
        !i_s_tready, "input stayed open after accept")

    // A finished or failed result commands no rotation
    `SYB_ASSERT_SAME(a_stop_rate, i_clk, i_rst_n, i_m_tvalid && (i_m_tuser != ST_RUN),
        i_m_tdata[15:0] == 16'd0, "non-zero rate on a stopped result")

endmodule

bind spin_yaw_braking_profile_core syb_checker u_syb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

>>> sim/tb_spin_yaw_braking_profile_core.sv
// Self-checking testbench for the spin yaw braking profile core
module tb_spin_yaw_braking_profile_core;
    import syb_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    // pi and 2*pi in the angle format, rounded from the package constant
    localparam longint PI_FX     = (PI_Q32 + (64'd1 << 19)) >>> 20;
    localparam longint TWO_PI_FX = (2 * PI_Q32 + (64'd1 << 19)) >>> 20;
    localparam longint ACC_MAX   = (64'sd1 <<< 23) - 1;
    localparam longint ACC_MIN   = -(64'sd1 <<< 23);
    localparam int     LONG_RUN  = 710;

    typedef struct {
        logic               op;
        logic signed [14:0] heading;
        logic signed [23:0] target;
        logic               pose_ok;
    } t_spin_cmd;

    typedef struct {
        logic [1:0]         status;
        logic signed [15:0] rate;
        logic signed [23:0] turned;
    } t_rate_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;   // [14:0] heading, [38:15] target_turn, [39] zero
    logic [1:0]  i_s_axis_tuser = '0;   // [0] op, [1] pose_valid
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;        // [15:0] rate_command, [39:16] turned_angle
    logic [1:0]  o_m_axis_tuser;        // [1:0] status
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_MAX_RATE;
    logic [15:0] i_cfg_data = '0;

    // Predictor copy of the limits and the spin state
    logic [14:0]        lim_max_rate  = MAX_RATE_RST;
    logic [14:0]        lim_min_rate  = MIN_RATE_RST;
    logic [15:0]        lim_accel     = ACCEL_RST;
    logic signed [15:0] prev_heading  = '0;
    logic signed [23:0] turn_acc      = '0;
    logic signed [23:0] turn_goal     = '0;

    t_spin_cmd pending_cmds[$];
    t_rate_cmd expected_rates[$];
    t_spin_cmd cur_word;

    logic word_live = 1'b0;
    logic hold_go = 1'b0;
    logic hold_rx = 1'b0;
    int   in_gap_max = 0;
    int   out_stall_max = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   queued = 0;
    int   words_sent = 0;
    int   done_seen = 0;
    int   nopose_seen = 0;
    int   limit_sets = 1;
    int   err_count = 0;
    int   ticks_run = 0;

    spin_yaw_braking_profile_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Floor square root, one result bit at a time
    function automatic longint unsigned floor_root(input longint unsigned x);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    // Advance the spin state by one word and return the rate command it yields
    function automatic t_rate_cmd braking_rate(input t_spin_cmd w);
        t_rate_cmd       r;
        longint          delta;
        longint          acc;
        longint          goal_mag;
        longint          acc_mag;
        longint          remaining;
        longint unsigned vel;
        r.status = ST_RUN;
        r.rate   = '0;
        if (!w.pose_ok) begin
            r.status = ST_FAIL;
        end else if (w.op == OP_START) begin
            prev_heading = w.heading;
            turn_acc     = '0;
            turn_goal    = w.target;
        end else begin
            delta = longint'(w.heading) - longint'(prev_heading);
            if (delta > PI_FX) delta = delta - TWO_PI_FX;
            else if (delta < -PI_FX) delta = delta + TWO_PI_FX;
            acc = longint'(turn_acc) + delta;
            if (acc > ACC_MAX) acc = ACC_MAX;
            else if (acc < ACC_MIN) acc = ACC_MIN;
            turn_acc     = acc[23:0];
            prev_heading = w.heading;
            goal_mag  = (turn_goal < 0) ? -longint'(turn_goal) : longint'(turn_goal);
            acc_mag   = (turn_acc < 0) ? -longint'(turn_acc) : longint'(turn_acc);
            remaining = goal_mag - acc_mag;
            if (remaining <= 0) begin
                r.status = ST_DONE;
            end else begin
                vel = floor_root(2 * longint'(lim_accel) * remaining);
                if (vel < lim_min_rate) vel = lim_min_rate;
                if (vel > lim_max_rate) vel = lim_max_rate;
                if (turn_goal < 0) r.rate = -vel[15:0];
                else r.rate = vel[15:0];
            end
        end
        r.turned = turn_acc;
        return r;
    endfunction

    function automatic t_spin_cmd spin_word(input logic op, input int hdg, input int tgt,
                                            input logic ok);
        t_spin_cmd w;
        w.op      = op;
        w.heading = hdg[14:0];
        w.target  = tgt[23:0];
        w.pose_ok = ok;
        return w;
    endfunction

    task automatic note_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic push_word(input t_spin_cmd w);
        pending_cmds.push_back(w);
        queued++;
    endtask

    // Keep a heading inside +-pi after a step
    function automatic int wrap_heading(input int h);
        if (h > PI_FX) return h - int'(TWO_PI_FX);
        if (h < -PI_FX) return h + int'(TWO_PI_FX);
        return h;
    endfunction

    // Queue a start and a walk of samples towards (and often past) the goal
    task automatic queue_spin(input int n_samples);
        int   h;
        int   t;
        int   dir;
        int   step;
        logic ok;
        h = $urandom_range(0, 25736) - 12868;
        case ($urandom_range(0, 2))
            0: t = $urandom_range(0, 20000);
            1: t = $urandom_range(0, 300000);
            default: t = $urandom_range(0, 8388607);
        endcase
        dir = $urandom_range(0, 1) ? 1 : -1;
        t   = t * dir;
        if ($urandom_range(0, 7) == 0) t = $signed(24'($urandom));
        push_word(spin_word(OP_START, h, t, $urandom_range(0, 15) != 0));
        for (int i = 0; i < n_samples; i++) begin
            case ($urandom_range(0, 9))
                0: step = $urandom_range(0, 8000) - 4000;
                1: step = $urandom_range(0, 25736) - 12868;
                default: step = dir * $urandom_range(0, 3000);
            endcase
            h  = wrap_heading(h + step);
            ok = $urandom_range(0, 11) != 0;
            push_word(spin_word(OP_SAMPLE, h, $urandom, ok));
        end
    endtask

    // Drive the turn all the way into accumulator saturation
    task automatic queue_long_spin(input logic negative);
        int h;
        h = $urandom_range(0, 25736) - 12868;
        push_word(spin_word(OP_START, h, negative ? -8388608 : 8388607, 1'b1));
        for (int i = 0; i < LONG_RUN; i++) begin
            if (negative) h = wrap_heading(h - $urandom_range(12000, 12800));
            else h = wrap_heading(h + $urandom_range(12000, 12800));
            push_word(spin_word(OP_SAMPLE, h, $urandom, 1'b1));
        end
    endtask

    // Mostly well-formed spins; one pick in ten is a single fully random word
    task automatic random_phase(input int n_words);
        int stop_at;
        stop_at = queued + n_words;
        while (queued < stop_at) begin
            if ($urandom_range(0, 9) == 0)
                push_word(spin_word(1'($urandom), $urandom, $urandom, 1'($urandom)));
            else
                queue_spin($urandom_range(1, 30));
        end
    endtask

    // Wait until every word has gone in and every result has come out
    task automatic settle();
        while (pending_cmds.size() != 0 || word_live || expected_rates.size() != 0)
            @(posedge i_clk);
    endtask

    // Write all three limit registers back to back; only while idle
    task automatic load_limits(input logic [14:0] mx, input logic [14:0] mn,
                               input logic [15:0] ac);
        logic [1:0]  idx [3];
        logic [15:0] val [3];
        idx = '{CFG_MAX_RATE, CFG_MIN_RATE, CFG_ACCEL};
        val = '{{1'b0, mx}, {1'b0, mn}, ac};
        for (int i = 0; i < 3; i++) begin
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            i_cfg_valid <= 1'b1;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        lim_max_rate = mx;
        lim_min_rate = mn;
        lim_accel    = ac;
        limit_sets++;
    endtask

    // Input driver: present queued words, predict each one as it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            word_live = 1'b0;
            gap_left  = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_rates.push_back(braking_rate(cur_word));
                word_live = 1'b0;
                words_sent++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    cur_word  = pending_cmds.pop_front();
                    word_live = 1'b1;
                    i_s_axis_tdata  <= {1'b0, cur_word.target, cur_word.heading};
                    i_s_axis_tuser  <= {cur_word.pose_ok, cur_word.op};
                    i_s_axis_tvalid <= 1'b1;
                    gap_left = $urandom_range(0, in_gap_max);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each word taken against the oldest prediction
    always @(posedge i_clk) begin
        t_rate_cmd want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_rates.size() == 0) begin
                    note_error($sformatf("result word with nothing predicted: tdata %h tuser %h",
                                         o_m_axis_tdata, o_m_axis_tuser));
                end else begin
                    want = expected_rates.pop_front();
                    if (o_m_axis_tuser !== want.status)
                        note_error($sformatf("status %0d, predicted %0d",
                                             o_m_axis_tuser, want.status));
                    if (o_m_axis_tdata[15:0] !== want.rate)
                        note_error($sformatf("rate_command %0d, predicted %0d",
                                             $signed(o_m_axis_tdata[15:0]), want.rate));
                    if (o_m_axis_tdata[39:16] !== want.turned)
                        note_error($sformatf("turned_angle %0d, predicted %0d",
                                             $signed(o_m_axis_tdata[39:16]), want.turned));
                    if (want.status == ST_DONE) done_seen++;
                    if (want.status == ST_FAIL) nopose_seen++;
                end
                stall_left = $urandom_range(0, out_stall_max);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_m_axis_tready <= (stall_left == 0) && !hold_rx;
        end
    end

    // Long receiver hold-off so the block fills and backs up its input
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    // Watchdog
    initial begin
        while (ticks_run < CYCLE_LIMIT) begin
            @(posedge i_clk);
            ticks_run++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at reset limits: pose loss, exact +-pi steps, unwrap both
        // ways, zero and negative remaining angle, both clamps, full-scale goals
        in_gap_max    = 16;
        out_stall_max = 16;
        push_word(spin_word(OP_SAMPLE, 0, 0, 1'b1));
        push_word(spin_word(OP_SAMPLE, 77, 0, 1'b0));
        push_word(spin_word(OP_START, 500, 5000, 1'b0));
        push_word(spin_word(OP_START, -16384, 8388607, 1'b1));
        push_word(spin_word(OP_SAMPLE, -3516, -8388608, 1'b1));
        push_word(spin_word(OP_SAMPLE, 16383, 0, 1'b1));
        push_word(spin_word(OP_SAMPLE, -16384, 0, 1'b1));
        push_word(spin_word(OP_START, 12868, -8388608, 1'b1));
        push_word(spin_word(OP_SAMPLE, 0, 0, 1'b1));
        push_word(spin_word(OP_SAMPLE, 0, 0, 1'b0));
        push_word(spin_word(OP_SAMPLE, -12869, 0, 1'b1));
        push_word(spin_word(OP_START, 100, 0, 1'b1));
        push_word(spin_word(OP_SAMPLE, 100, 0, 1'b1));
        push_word(spin_word(OP_START, 0, 1, 1'b1));
        push_word(spin_word(OP_SAMPLE, 0, 0, 1'b1));
        push_word(spin_word(OP_SAMPLE, 1, 0, 1'b1));
        push_word(spin_word(OP_SAMPLE, 5, 0, 1'b1));
        push_word(spin_word(OP_START, 0, -4096, 1'b1));
        push_word(spin_word(OP_SAMPLE, -3796, 0, 1'b1));
        push_word(spin_word(OP_SAMPLE, -3700, 8388607, 1'b1));
        push_word(spin_word(OP_SAMPLE, 12868, 0, 1'b1));
        settle();

        // Top limits, no idling, plus the long receiver hold-off
        load_limits(15'd32767, 15'd0, 16'd65535);
        in_gap_max    = 0;
        out_stall_max = 0;
        random_phase(120);
        hold_go <= 1'b1;
        settle();

        // Zero rate ceiling with the floor above it, and zero acceleration
        load_limits(15'd0, 15'd32767, 16'd0);
        in_gap_max    = 16;
        out_stall_max = 16;
        random_phase(90);
        settle();

        load_limits(15'd1000, 15'd5000, 16'd1);
        in_gap_max    = 3;
        out_stall_max = 16;
        random_phase(90);
        settle();

        // Back to the reset limits for the saturating spins
        load_limits(MAX_RATE_RST, MIN_RATE_RST, ACCEL_RST);
        in_gap_max    = 2;
        out_stall_max = 2;
        queue_long_spin(1'b0);
        queue_long_spin(1'b1);
        settle();

        // Random limits with mixed idling
        for (int p = 0; p < 3; p++) begin
            load_limits(15'($urandom), 15'($urandom), 16'($urandom));
            in_gap_max    = (p == 1) ? 0 : 16;
            out_stall_max = (p == 2) ? 0 : 16;
            random_phase(100);
            settle();
        end

        // Let any stray result show up
        repeat (60) @(posedge i_clk);
        if (expected_rates.size() != 0)
            note_error($sformatf("%0d predicted results never arrived", expected_rates.size()));

        $display("covered %0d words under %0d limit settings: %0d turns complete, %0d without pose",
                 words_sent, limit_sets, done_seen, nopose_seen);
        $display("%0d cycles, %0d mismatches", ticks_run, err_count);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
